@@ rtl/core/pcmf_pkg.sv @@
// ----------------------------------------------------------------------------
// pcmf_pkg - shared types and functions of the permutation candidate filter
// Widths, the word carried along the cell chain, the elaboration-time
// factorial schedule and the GF(2^4) mix helpers.
// ----------------------------------------------------------------------------
package pcmf_pkg;

    localparam int IDX_W    = 37;
    localparam int WORD_W   = 16;
    localparam int NIB_W    = 4;
    localparam int DIG_W    = 4;
    localparam int MAX_FREE = 14;
    localparam int FREE_VALUES_DEF = 14;
    localparam longint IDX_MAX = (longint'(1) << IDX_W) - 1;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_WORD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_WORD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPARE_MASK = 2'd2;

    localparam logic [WORD_W-1:0] FIRST_WORD_RST   = 16'h0000;
    localparam logic [WORD_W-1:0] SECOND_WORD_RST  = 16'h0000;
    localparam logic [WORD_W-1:0] COMPARE_MASK_RST = 16'h0FFF;

    localparam logic [NIB_W-1:0] GF_POLY_LOW = 4'h3;

    typedef logic [MAX_FREE-1:0][DIG_W-1:0] t_digits;
    typedef logic [MAX_FREE-1:0][NIB_W-1:0] t_list;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic [IDX_W-1:0] rest;
        t_digits          digits;
        logic             sat;
        t_list            list;
    } t_word;

    function automatic longint fact(input int n);
        longint r;
        r = 1;
        for (int i = 2; i <= n; i++) begin
            r = r * i;
        end
        return r;
    endfunction

    function automatic int nbits(input longint v);
        int b;
        b = 0;
        for (int i = 0; i < 63; i++) begin
            if ((v >> i) != 0) begin
                b = i + 1;
            end
        end
        return b;
    endfunction

    function automatic int top_steps(input int f);
        int n;
        n = 0;
        for (int s = 0; s <= IDX_W; s++) begin
            if (fact(f - 1) <= (IDX_MAX >> s)) begin
                n = s + 1;
            end
        end
        return n;
    endfunction

    function automatic int dig_steps(input int f, input int k);
        int n;
        if (k == f - 1) begin
            n = top_steps(f);
        end else begin
            n = nbits(longint'(k));
        end
        return n;
    endfunction

    function automatic int total_steps(input int f);
        int n;
        n = 0;
        for (int k = 0; k < f; k++) begin
            n = n + dig_steps(f, k);
        end
        return n;
    endfunction

    // digit handled by step j, walking digits from the top down
    function automatic int step_k(input int f, input int j);
        int c;
        int r;
        c = 0;
        r = 0;
        for (int k = f - 1; k >= 0; k--) begin
            for (int s = dig_steps(f, k) - 1; s >= 0; s--) begin
                if (c == j) begin
                    r = k;
                end
                c = c + 1;
            end
        end
        return r;
    endfunction

    function automatic int step_s(input int f, input int j);
        int c;
        int r;
        c = 0;
        r = 0;
        for (int k = f - 1; k >= 0; k--) begin
            for (int s = dig_steps(f, k) - 1; s >= 0; s--) begin
                if (c == j) begin
                    r = s;
                end
                c = c + 1;
            end
        end
        return r;
    endfunction

    function automatic logic [NIB_W-1:0] gf_dbl(input logic [NIB_W-1:0] v);
        return {v[NIB_W-2:0], 1'b0} ^ (v[NIB_W-1] ? GF_POLY_LOW : '0);
    endfunction

    // coefficient of row i, column j of the circulant (2,3,1,1)
    function automatic logic [NIB_W-1:0] gf_term(input int i, input int j,
                                                 input logic [NIB_W-1:0] v);
        logic [NIB_W-1:0] r;
        case ((j - i + 4) % 4)
            0:       r = gf_dbl(v);
            1:       r = gf_dbl(v) ^ v;
            default: r = v;
        endcase
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] mix_word(input logic [WORD_W-1:0] w);
        logic [3:0][NIB_W-1:0] nib;
        logic [3:0][NIB_W-1:0] res;
        for (int i = 0; i < 4; i++) begin
            nib[i] = w[(3 - i) * NIB_W +: NIB_W];
        end
        for (int i = 0; i < 4; i++) begin
            res[3 - i] = '0;
            for (int j = 0; j < 4; j++) begin
                res[3 - i] = res[3 - i] ^ gf_term(i, j, nib[j]);
            end
        end
        return res;
    endfunction

endpackage

@@ rtl/core/pcmf_div_cell.sv @@
// ----------------------------------------------------------------------------
// pcmf_div_cell - one restoring step of the factorial digit extraction
// Compares the remainder with a shifted factorial, subtracts on success and
// sets the matching digit bit, or the overflow flag for the top digit.
// ----------------------------------------------------------------------------
module pcmf_div_cell
    import pcmf_pkg::*;
#(
    parameter longint DIVISOR = 1,
    parameter int     SHIFT   = 0,
    parameter int     DIGIT   = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_word i_word,
    output logic  o_valid,
    output t_word o_word
);

    localparam logic [IDX_W-1:0] STEP_VAL = IDX_W'(DIVISOR << SHIFT);
    localparam int SBIT = (SHIFT < DIG_W) ? SHIFT : 0;

    logic  r_valid;
    t_word r_word;
    t_word n_word;

    always_comb begin
        n_word = i_word;
        if (i_word.rest >= STEP_VAL) begin
            n_word.rest = i_word.rest - STEP_VAL;
            if (SHIFT < DIG_W) begin
                n_word.digits[DIGIT][SBIT] = 1'b1;
            end else begin
                n_word.sat = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

@@ rtl/core/pcmf_ins_cell.sv @@
// ----------------------------------------------------------------------------
// pcmf_ins_cell - one insertion step of the permutation build
// Inserts the value K+2 into the growing list at the position given by
// digit K, saturating the top digit.
// ----------------------------------------------------------------------------
module pcmf_ins_cell
    import pcmf_pkg::*;
#(
    parameter int K   = 0,
    parameter bit TOP = 1'b0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_word i_word,
    output logic  o_valid,
    output t_word o_word
);

    localparam logic [DIG_W-1:0] K_D   = DIG_W'(K);
    localparam logic [NIB_W-1:0] K_VAL = NIB_W'(K + 2);

    logic             r_valid;
    t_word            r_word;
    t_word            n_word;
    logic [DIG_W-1:0] pos;

    always_comb begin
        pos = i_word.digits[K];
        if ((TOP && i_word.sat) || (pos > K_D)) begin
            pos = K_D;
        end
        n_word = i_word;
        for (int i = 0; i < MAX_FREE; i++) begin
            if (DIG_W'(i) == pos) begin
                n_word.list[i] = K_VAL;
            end else if (i > 0 && DIG_W'(i) > pos) begin
                n_word.list[i] = i_word.list[(i > 0) ? i - 1 : 0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

@@ rtl/core/pcmf_mix_stage.sv @@
// ----------------------------------------------------------------------------
// pcmf_mix_stage - substitution, mix and masked compare
// Builds the nibble permutation from the list, substitutes both words,
// mixes them and registers the match flag with the index.
// ----------------------------------------------------------------------------
module pcmf_mix_stage
    import pcmf_pkg::*;
#(
    parameter int FREE_VALUES = FREE_VALUES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  t_word             i_word,
    input  logic [WORD_W-1:0] i_first_word,
    input  logic [WORD_W-1:0] i_second_word,
    input  logic [WORD_W-1:0] i_compare_mask,
    output logic              o_valid,
    output logic [IDX_W-1:0]  o_index,
    output logic              o_match
);

    logic [15:0][NIB_W-1:0] perm;
    logic [WORD_W-1:0]      sub_a;
    logic [WORD_W-1:0]      sub_b;
    logic [WORD_W-1:0]      diff;
    logic                   r_valid;
    logic [IDX_W-1:0]       r_index;
    logic                   r_match;

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            perm[i] = NIB_W'(i);
        end
        for (int k = 0; k < FREE_VALUES; k++) begin
            perm[2 + k] = i_word.list[FREE_VALUES - 1 - k];
        end
        for (int i = 0; i < 4; i++) begin
            sub_a[i * NIB_W +: NIB_W] = perm[i_first_word[i * NIB_W +: NIB_W]];
            sub_b[i * NIB_W +: NIB_W] = perm[i_second_word[i * NIB_W +: NIB_W]];
        end
        diff = (mix_word(sub_a) ^ mix_word(sub_b)) & i_compare_mask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_index <= i_word.index;
            r_match <= (diff == '0);
        end
    end

    assign o_valid = r_valid;
    assign o_index = r_index;
    assign o_match = r_match;

endmodule

@@ rtl/core/permutation_candidate_mds_filter.sv @@
// ----------------------------------------------------------------------------
// permutation_candidate_mds_filter - permutation candidate filter top level
// Unranks a candidate index into a nibble permutation, substitutes and
// mixes the two configured words and flags a masked match.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid/o_ready carries one candidate index per word.
//   Output channel o_valid/i_ready returns the echoed index and the match
//   flag, exactly one result word per input word, in order.
//   Config channel i_cfg_valid/o_cfg_ready writes first word (0), second
//   word (1) or compare mask (2); other indexes are ignored. Write only
//   while the block is idle.
//   Throughput: one word per cycle while the output is not stalled, set by the chain of single-step cells.
//   Registers: one per restoring division step, one per insertion cell,
//   one for the mix stage and one for the output register, in that order.
//   Reset empties the chain and loads the register reset values.
//   When the receiver stalls, one more result lands in a skid register,
//   after which the whole chain holds until the skid empties into the output.
// ----------------------------------------------------------------------------
module permutation_candidate_mds_filter
    import pcmf_pkg::*;
#(
    parameter int FREE_VALUES = FREE_VALUES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [IDX_W-1:0]     i_candidate_index,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [IDX_W-1:0]     o_echoed_index,
    output logic                 o_match,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data
);

    localparam int NSTEP = total_steps(FREE_VALUES);

    logic [WORD_W-1:0] r_first_word;
    logic [WORD_W-1:0] r_second_word;
    logic [WORD_W-1:0] r_compare_mask;

    logic             en;
    t_word            div_w [NSTEP+1];
    logic             div_v [NSTEP+1];
    t_word            ins_w [FREE_VALUES+1];
    logic             ins_v [FREE_VALUES+1];
    logic             mix_v;
    logic [IDX_W-1:0] mix_index;
    logic             mix_match;

    logic             r_out_valid;
    logic [IDX_W-1:0] r_out_index;
    logic             r_out_match;
    logic             r_skid_valid;
    logic [IDX_W-1:0] r_skid_index;
    logic             r_skid_match;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_word   <= FIRST_WORD_RST;
            r_second_word  <= SECOND_WORD_RST;
            r_compare_mask <= COMPARE_MASK_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FIRST_WORD:   r_first_word   <= i_cfg_data;
                CFG_SECOND_WORD:  r_second_word  <= i_cfg_data;
                CFG_COMPARE_MASK: r_compare_mask <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign en      = !r_skid_valid;
    assign o_ready = en;

    always_comb begin
        div_v[0]        = i_valid;
        div_w[0].index  = i_candidate_index;
        div_w[0].rest   = i_candidate_index;
        div_w[0].digits = '0;
        div_w[0].sat    = 1'b0;
        div_w[0].list   = '0;
    end

    for (genvar j = 0; j < NSTEP; j++) begin : g_div
        pcmf_div_cell #(
            .DIVISOR (fact(step_k(FREE_VALUES, j))),
            .SHIFT   (step_s(FREE_VALUES, j)),
            .DIGIT   (step_k(FREE_VALUES, j))
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (div_v[j]),
            .i_word  (div_w[j]),
            .o_valid (div_v[j+1]),
            .o_word  (div_w[j+1])
        );
    end

    assign ins_v[0] = div_v[NSTEP];
    assign ins_w[0] = div_w[NSTEP];

    for (genvar k = 0; k < FREE_VALUES; k++) begin : g_ins
        pcmf_ins_cell #(
            .K   (k),
            .TOP (k == FREE_VALUES - 1)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (ins_v[k]),
            .i_word  (ins_w[k]),
            .o_valid (ins_v[k+1]),
            .o_word  (ins_w[k+1])
        );
    end

    pcmf_mix_stage #(
        .FREE_VALUES (FREE_VALUES)
    ) u_mix (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_valid        (ins_v[FREE_VALUES]),
        .i_word         (ins_w[FREE_VALUES]),
        .i_first_word   (r_first_word),
        .i_second_word  (r_second_word),
        .i_compare_mask (r_compare_mask),
        .o_valid        (mix_v),
        .o_index        (mix_index),
        .o_match        (mix_match)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (i_ready) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (mix_v) begin
            if (!r_out_valid || i_ready) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (i_ready) begin
                r_out_index <= r_skid_index;
                r_out_match <= r_skid_match;
            end
        end else if (mix_v) begin
            if (!r_out_valid || i_ready) begin
                r_out_index <= mix_index;
                r_out_match <= mix_match;
            end else begin
                r_skid_index <= mix_index;
                r_skid_match <= mix_match;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_echoed_index = r_out_index;
    assign o_match        = r_out_match;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a word while the output register is empty");

    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !i_ready))
        else $error("skid filled without an output stall");

    a_rest_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_v[NSTEP] |-> (div_w[NSTEP].rest == '0))
        else $error("factorial digit extraction left a remainder");

endmodule
